// ===== sv/kea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kea_pkg
// Shared types and constants for the keyed extent aggregator.
// ----------------------------------------------------------------------------
package kea_pkg;

  localparam int NUM_KEYS     = 4096;
  localparam int TIME_BITS    = 40;
  localparam int ADDR_W       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int KEY_W        = 12;
  localparam int MAG_W        = 12;
  localparam int FIELD_TIME_W = 40;

  localparam logic [MAG_W-1:0] MAG_TOTAL   = MAG_W'(1020);
  localparam logic [MAG_W-1:0] MAG_ANNULAR = MAG_W'(1010);

  typedef enum logic [1:0] {
    CMD_SEED   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_PATH   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                    command;
    logic [KEY_W-1:0]        key;
    logic [MAG_W-1:0]        magnitude;
    logic                    path_total;
    logic [FIELD_TIME_W-1:0] sample_partial_start;
    logic [FIELD_TIME_W-1:0] sample_total_start;
    logic [FIELD_TIME_W-1:0] sample_total_end;
    logic [FIELD_TIME_W-1:0] sample_partial_end;
    logic [FIELD_TIME_W-1:0] point_time;
  } in_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]        out_key;
    logic [MAG_W-1:0]        out_magnitude;
    logic [FIELD_TIME_W-1:0] out_partial_start;
    logic [FIELD_TIME_W-1:0] out_total_start;
    logic [FIELD_TIME_W-1:0] out_total_end;
    logic [FIELD_TIME_W-1:0] out_partial_end;
    logic                    changed;
  } out_res_t;

  // One stored record: magnitude and four times
  typedef struct packed {
    logic [MAG_W-1:0]     mag;
    logic [TIME_BITS-1:0] ps;
    logic [TIME_BITS-1:0] ts;
    logic [TIME_BITS-1:0] te;
    logic [TIME_BITS-1:0] pe;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/keyed_extent_aggregator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_extent_aggregator
// Per-key record of peak magnitude and partial/total contact times.
// ----------------------------------------------------------------------------
// Each request reads the key's record from the single record RAM, then
// updates it, writes it back and loads the result register, waiting while
// the output register holds an unclaimed result. The read-modify-write on
// that RAM sets the rate; a new request is taken as soon as the previous
// one has been written back, while its result may still wait in the output
// register. A clearing pass after reset writes all NUM_KEYS (4096) records
// with in_ready low; requests to key zero or beyond NUM_KEYS change no state.
module keyed_extent_aggregator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kea_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kea_pkg::out_res_t out_data
);
  import kea_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  kea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kea_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a result only lands in a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwrote an unclaimed result");

  // no requests while the record RAM is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> (!in_ready && !cmd.commit))
    else $error("request path active during clearing pass");

  // with the output register free, an accepted request commits in the next cycle
  a_commit_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> cmd.commit)
    else $error("request did not complete with a free output register");

endmodule

// ===== sv/kea_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kea_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module kea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/kea_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kea_ctrl
// Sequencer: clearing pass after reset, then read / update per request.
// ----------------------------------------------------------------------------
module kea_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kea_pkg::dp_status_t status,
  output kea_pkg::ctrl_cmd_t  cmd
);
  import kea_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  always_comb begin
    cmd.clear_step = (state_r == S_CLEAR);
    cmd.capture    = (state_r == S_IDLE) && in_valid && in_ready_r;
    cmd.commit     = (state_r == S_CALC) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (status.clear_last) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_CALC;
            in_ready_r <= 1'b0;
          end
        end
        S_CALC: begin
          // wait here while the previous result is still unclaimed
          if (status.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_CLEAR;
          in_ready_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== sv/kea_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kea_datapath
// Record RAM, request register, record update logic and result register.
// ----------------------------------------------------------------------------
module kea_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  kea_pkg::ctrl_cmd_t  cmd,
  output kea_pkg::dp_status_t status,
  input  kea_pkg::in_req_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kea_pkg::out_res_t   out_data
);
  import kea_pkg::*;

  in_req_t           req_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] clr_cnt_nxt;
  logic              out_valid_r;
  out_res_t          out_r;
  out_res_t          res_nxt;

  rec_t              cur;
  rec_t              upd;
  logic [REC_W-1:0]  rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [REC_W-1:0]  ram_wdata;
  logic              key_ok;

  logic [TIME_BITS-1:0] s_ps, s_ts, s_te, s_pe, pt;
  logic [MAG_W-1:0]     path_mag;

  function automatic logic [TIME_BITS-1:0] earlier_of(
    input logic [TIME_BITS-1:0] c,
    input logic [TIME_BITS-1:0] s
  );
    logic take;
    take = (s != '0) && ((c == '0) || (s < c));
    return take ? s : c;
  endfunction

  function automatic logic [TIME_BITS-1:0] later_of(
    input logic [TIME_BITS-1:0] c,
    input logic [TIME_BITS-1:0] s
  );
    logic take;
    take = (s != '0) && ((c == '0) || (s > c));
    return take ? s : c;
  endfunction

  kea_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_KEYS),
    .AW    (ADDR_W)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (ADDR_W'(in_data.key)),
    .rdata (rdata)
  );

  assign cur    = rec_t'(rdata);
  assign key_ok = (32'(req_r.key) < NUM_KEYS);

  assign s_ps     = TIME_BITS'(req_r.sample_partial_start);
  assign s_ts     = TIME_BITS'(req_r.sample_total_start);
  assign s_te     = TIME_BITS'(req_r.sample_total_end);
  assign s_pe     = TIME_BITS'(req_r.sample_partial_end);
  assign pt       = TIME_BITS'(req_r.point_time);
  assign path_mag = req_r.path_total ? MAG_TOTAL : MAG_ANNULAR;

  always_comb begin
    upd = cur;
    if (req_r.key != '0) begin
      unique case (req_r.command)
        CMD_SEED: begin
          upd.mag = req_r.magnitude;
          upd.ps  = s_ps;
          upd.ts  = s_ts;
          upd.te  = s_te;
          upd.pe  = s_pe;
        end
        CMD_SAMPLE: begin
          if (req_r.magnitude != '0) begin
            if (req_r.magnitude > cur.mag) begin
              upd.mag = req_r.magnitude;
            end
            upd.ps = earlier_of(cur.ps, s_ps);
            upd.ts = earlier_of(cur.ts, s_ts);
            upd.te = later_of(cur.te, s_te);
            upd.pe = later_of(cur.pe, s_pe);
          end
        end
        CMD_PATH: begin
          if (path_mag > cur.mag) begin
            upd.mag = path_mag;
          end
          // an unset total time takes the point time, even a zero one
          if ((cur.ts == '0) || (pt < cur.ts)) begin
            upd.ts = pt;
          end
          if ((cur.te == '0) || (pt > cur.te)) begin
            upd.te = pt;
          end
        end
        CMD_READ: begin
          upd = cur;
        end
        default: begin
          upd = cur;
        end
      endcase
    end
  end

  always_comb begin
    res_nxt         = '0;
    res_nxt.out_key = req_r.key;
    if (key_ok) begin
      res_nxt.out_magnitude     = upd.mag;
      res_nxt.out_partial_start = FIELD_TIME_W'(upd.ps);
      res_nxt.out_total_start   = FIELD_TIME_W'(upd.ts);
      res_nxt.out_total_end     = FIELD_TIME_W'(upd.te);
      res_nxt.out_partial_end   = FIELD_TIME_W'(upd.pe);
      res_nxt.changed           = (upd != cur);
    end
  end

  // clearing pass owns the write port until it is done
  always_comb begin
    ram_we    = cmd.clear_step || (cmd.commit && key_ok);
    ram_waddr = cmd.clear_step ? clr_cnt_r : ADDR_W'(req_r.key);
    ram_wdata = cmd.clear_step ? '0 : REC_W'(upd);
  end

  assign clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= res_nxt;
    end
  end

  assign status.clear_last = (clr_cnt_r == ADDR_W'(NUM_KEYS - 1));
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== test/keyed_extent_aggregator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_extent_aggregator_test
// Self-checking bench for the keyed extent aggregator. A directed opener
// covers seeding, magnitude and time extremes, ignored requests, path points
// of both kinds and repeat writes. A random part follows, made mostly of
// per-key runs: an optional seed, then samples, path points and reads on the
// same key, with some stray requests mixed in. A predictor keeps its own copy
// of every record and checks each result field by field. Both sides idle and
// stall in random bursts.
// ----------------------------------------------------------------------------
module keyed_extent_aggregator_test;
  import kea_pkg::*;

  localparam int RANDOM_REQUESTS = 1200;
  localparam int QUIET_TAIL      = 200;     // last requests run with no idling
  localparam int CYCLE_LIMIT     = 200000;
  localparam int KEY_POOL        = 12;      // hot keys 1..KEY_POOL for accumulation
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_data;

  in_req_t  pending_requests[$];
  out_res_t expected_records[$];
  rec_t     records[NUM_KEYS];

  int in_gap = 0;
  int out_gap = 0;
  int cycles = 0;
  int mismatches = 0;
  int results_checked = 0;
  int records_changed = 0;
  int cmd_count[4] = '{0, 0, 0, 0};

  keyed_extent_aggregator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [TIME_BITS-1:0] earliest(logic [TIME_BITS-1:0] cur,
                                                    logic [TIME_BITS-1:0] s);
    return (s != 0 && (cur == 0 || s < cur)) ? s : cur;
  endfunction

  function automatic logic [TIME_BITS-1:0] latest(logic [TIME_BITS-1:0] cur,
                                                  logic [TIME_BITS-1:0] s);
    return (s != 0 && (cur == 0 || s > cur)) ? s : cur;
  endfunction

  function automatic out_res_t update_record(in_req_t req);
    rec_t             cur;
    rec_t             nxt;
    out_res_t         res;
    logic [MAG_W-1:0] peak;
    res = '0;
    res.out_key = req.key;
    if (int'(req.key) >= NUM_KEYS) return res;
    cur = records[req.key];
    nxt = cur;
    if (req.key != 0) begin
      case (req.command)
        CMD_SEED: begin
          nxt.mag = req.magnitude;
          nxt.ps  = req.sample_partial_start;
          nxt.ts  = req.sample_total_start;
          nxt.te  = req.sample_total_end;
          nxt.pe  = req.sample_partial_end;
        end
        CMD_SAMPLE: begin
          if (req.magnitude != 0) begin
            if (req.magnitude > nxt.mag) nxt.mag = req.magnitude;
            nxt.ps = earliest(nxt.ps, req.sample_partial_start);
            nxt.ts = earliest(nxt.ts, req.sample_total_start);
            nxt.te = latest(nxt.te, req.sample_total_end);
            nxt.pe = latest(nxt.pe, req.sample_partial_end);
          end
        end
        CMD_PATH: begin
          peak = req.path_total ? MAG_TOTAL : MAG_ANNULAR;
          if (peak > nxt.mag) nxt.mag = peak;
          // unset total times take the point time, zero included
          if (nxt.ts == 0 || req.point_time < nxt.ts) nxt.ts = req.point_time;
          if (nxt.te == 0 || req.point_time > nxt.te) nxt.te = req.point_time;
        end
        default: ;
      endcase
    end
    records[req.key] = nxt;
    res.out_magnitude     = nxt.mag;
    res.out_partial_start = nxt.ps;
    res.out_total_start   = nxt.ts;
    res.out_total_end     = nxt.te;
    res.out_partial_end   = nxt.pe;
    res.changed           = (nxt != cur);
    return res;
  endfunction

  // ----------------------------------------------------------------- stimulus
  function automatic in_req_t make_req(cmd_t cmd, int key, int mag, bit total,
                                       logic [TIME_BITS-1:0] ps,
                                       logic [TIME_BITS-1:0] ts,
                                       logic [TIME_BITS-1:0] te,
                                       logic [TIME_BITS-1:0] pe,
                                       logic [TIME_BITS-1:0] pt);
    in_req_t req;
    req.command              = cmd;
    req.key                  = KEY_W'(key);
    req.magnitude            = MAG_W'(mag);
    req.path_total           = total;
    req.sample_partial_start = ps;
    req.sample_total_start   = ts;
    req.sample_total_end     = te;
    req.sample_partial_end   = pe;
    req.point_time           = pt;
    return req;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 45) return TIME_BITS'($urandom_range(1, 2000));
    if (r < 52) return TIME_MAX - TIME_BITS'($urandom_range(0, 3));
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic int rand_mag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 0;
    if (r < 20) return 4095;
    if (r < 60) return $urandom_range(900, 1100);  // around path magnitudes
    return $urandom_range(0, 4095);
  endfunction

  function automatic int rand_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 18) return $urandom_range(0, 4095);
    if (r < 22) return 4095;
    return $urandom_range(1, KEY_POOL);
  endfunction

  function automatic in_req_t build_req(cmd_t cmd, int key);
    return make_req(cmd, key, rand_mag(), 1'($urandom), rand_time(), rand_time(),
                    rand_time(), rand_time(), rand_time());
  endfunction

  initial begin
    int   added;
    int   key;
    int   run_len;
    int   r;
    cmd_t cmd;

    // every record starts out cleared
    foreach (records[i]) records[i] = '0;

    // directed opener
    pending_requests.push_back(make_req(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(CMD_SEED, 0, 4095, 1, TIME_MAX, TIME_MAX,
                                        TIME_MAX, TIME_MAX, TIME_MAX));
    pending_requests.push_back(make_req(CMD_SAMPLE, 0, 4095, 1, 1, 1, 1, 1, 1));
    pending_requests.push_back(make_req(CMD_PATH, 0, 0, 1, 0, 0, 0, 0, 77));
    pending_requests.push_back(make_req(CMD_SEED, 1, 500, 0, 100, 200, 300, 400, 0));
    // zero magnitude sample is ignored
    pending_requests.push_back(make_req(CMD_SAMPLE, 1, 0, 0, 1, 1, 999, 999, 0));
    pending_requests.push_back(make_req(CMD_SAMPLE, 1, 600, 0, 50, 0, 350, 0, 0));
    pending_requests.push_back(make_req(CMD_SAMPLE, 1, 4095, 1, TIME_MAX, TIME_MAX,
                                        TIME_MAX, TIME_MAX, TIME_MAX));
    pending_requests.push_back(make_req(CMD_SAMPLE, 1, 1, 0, 0, 0, 0, 0, 0));
    // unset record fields take any nonzero sample
    pending_requests.push_back(make_req(CMD_SAMPLE, 2, 1, 0, 5, 6, 7, 8, 0));
    // path point at time zero into unset total times
    pending_requests.push_back(make_req(CMD_PATH, 3, 0, 1, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(CMD_PATH, 3, 0, 0, 0, 0, 0, 0, 1000));
    pending_requests.push_back(make_req(CMD_PATH, 3, 0, 1, 0, 0, 0, 0, 500));
    pending_requests.push_back(make_req(CMD_PATH, 3, 0, 0, 0, 0, 0, 0, TIME_MAX));
    pending_requests.push_back(make_req(CMD_PATH, 4, 0, 0, 0, 0, 0, 0, 123));
    pending_requests.push_back(make_req(CMD_SEED, 4, 2000, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(CMD_PATH, 4, 0, 1, 0, 0, 0, 0, 7));
    pending_requests.push_back(make_req(CMD_SEED, 4095, 4095, 1, TIME_MAX, TIME_MAX,
                                        TIME_MAX, TIME_MAX, TIME_MAX));
    pending_requests.push_back(make_req(CMD_READ, 4095, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(CMD_SEED, 4095, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(CMD_SEED, 4095, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(CMD_READ, 4095, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(CMD_READ, 0, 4095, 1, TIME_MAX, TIME_MAX,
                                        TIME_MAX, TIME_MAX, TIME_MAX));

    // random runs on one key, with stray requests in between
    added = 0;
    while (added < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 99) < 80) begin
        key = rand_key();
        if ($urandom_range(0, 2) == 0) begin
          pending_requests.push_back(build_req(CMD_SEED, key));
          added++;
        end
        run_len = $urandom_range(3, 10);
        repeat (run_len) begin
          r = $urandom_range(0, 99);
          cmd = (r < 55) ? CMD_SAMPLE : (r < 75) ? CMD_PATH : (r < 90) ? CMD_READ : CMD_SEED;
          pending_requests.push_back(build_req(cmd, key));
          added++;
        end
      end else begin
        pending_requests.push_back(build_req(cmd_t'($urandom_range(0, 3)), rand_key()));
        added++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d results: %0d seed, %0d sample, %0d path, %0d read requests;",
             results_checked, cmd_count[CMD_SEED], cmd_count[CMD_SAMPLE],
             cmd_count[CMD_PATH], cmd_count[CMD_READ]);
    $display("%0d of them altered a record.", records_changed);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ------------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_records.push_back(update_record(in_data));
        cmd_count[in_data.command]++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
          in_gap   <= $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_requests.pop_front();
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(out_res_t got);
    out_res_t want;
    if (expected_records.size() == 0) begin
      $error("result for key %0d with no request outstanding", got.out_key);
      mismatches++;
      return;
    end
    want = expected_records.pop_front();
    results_checked++;
    if (want.changed) records_changed++;
    compare_field("out_key", want.out_key, got.out_key);
    compare_field("out_magnitude", want.out_magnitude, got.out_magnitude);
    compare_field("out_partial_start", want.out_partial_start, got.out_partial_start);
    compare_field("out_total_start", want.out_total_start, got.out_total_start);
    compare_field("out_total_end", want.out_total_end, got.out_total_end);
    compare_field("out_partial_end", want.out_partial_end, got.out_partial_end);
    compare_field("changed", want.changed, got.changed);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (out_gap > 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        out_gap   <= $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------ timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
